// ===== sv/table_spn_block_cipher_top_macros.svh =====
// Assertion macros for the table SPN block cipher.
`ifndef TABLE_SPN_BLOCK_CIPHER_TOP_MACROS_SVH
`define TABLE_SPN_BLOCK_CIPHER_TOP_MACROS_SVH

`ifndef SYNTH
// Check that a property holds on every clock edge outside reset.
`define TSPN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds on any clock edge outside reset.
`define TSPN_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TSPN_ASSERT(lbl, prop, msg)
`define TSPN_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== sv/tspn_pkg.sv =====
// Types and constants shared by the table SPN block cipher modules.
package tspn_pkg;

  localparam int WORD_W      = 16;
  localparam int WORD_COUNT  = 8;
  localparam int TABLE_WORDS = 1 << 16;
  localparam int ADDR_W      = $clog2(TABLE_WORDS);
  localparam int SEL_W       = $clog2(WORD_COUNT);
  localparam int HALF_W      = 64;
  localparam int ROUNDS_W    = 6;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 6'd12;

  // Register index, taken from paddr[2]
  localparam logic REG_ROUND_COUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD_ENC = 2'd0,
    CMD_LOAD_DEC = 2'd1,
    CMD_ENCRYPT  = 2'd2,
    CMD_DECRYPT  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [SEL_W-1:0]   table_sel;
    logic [ADDR_W-1:0]  table_addr;
    logic [WORD_W-1:0]  table_data;
    logic [HALF_W-1:0]  block_lo;
    logic [HALF_W-1:0]  block_hi;
  } in_beat_t;

  typedef struct packed {
    logic [HALF_W-1:0] result_lo;
    logic [HALF_W-1:0] result_hi;
  } out_beat_t;

  // Eight words, word 0 in the lowest bits
  typedef logic [WORD_COUNT-1:0][WORD_W-1:0] words_t;

  // Per-lane table control
  typedef struct packed {
    logic rd_en;
    logic dec;
    logic wr_enc;
    logic wr_dec;
  } lane_ctrl_t;

endpackage

// ===== sv/tspn_lane.sv =====
// One substitution lane: encrypt and decrypt tables for one word position.
module tspn_lane
  import tspn_pkg::*;
(
  input  logic              clk_i,
  input  lane_ctrl_t        ctrl_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] enc_mem [TABLE_WORDS];
  logic [WORD_W-1:0] dec_mem [TABLE_WORDS];
  logic [WORD_W-1:0] rd_data_q;

  // Write the encryption table on a load beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_enc) begin
      enc_mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Write the decryption table on a load beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_dec) begin
      dec_mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Look up the substituted word, hold it until the next read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      if (ctrl_i.dec) begin
        rd_data_q <= dec_mem[rd_addr_i];
      end else begin
        rd_data_q <= enc_mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/tspn_mix.sv =====
// XOR diffusion layer merging the eight lane words.
module tspn_mix
  import tspn_pkg::*;
(
  input  words_t w_i,
  output words_t w_o
);

  // Combine the words through the fixed binary matrix
  always_comb begin
    w_o[0] = w_i[1] ^ w_i[2] ^ w_i[3] ^ w_i[4] ^ w_i[7];
    w_o[1] = w_i[0] ^ w_i[1] ^ w_i[4] ^ w_i[5] ^ w_i[7];
    w_o[2] = w_i[0] ^ w_i[1] ^ w_i[2] ^ w_i[5] ^ w_i[6];
    w_o[3] = w_i[0] ^ w_i[1] ^ w_i[2] ^ w_i[3] ^ w_i[6] ^ w_i[7];
    w_o[4] = w_i[2] ^ w_i[3] ^ w_i[5] ^ w_i[6] ^ w_i[7];
    w_o[5] = w_i[0] ^ w_i[2] ^ w_i[4] ^ w_i[5];
    w_o[6] = w_i[0] ^ w_i[1] ^ w_i[3] ^ w_i[4] ^ w_i[5] ^ w_i[6];
    w_o[7] = w_i[1] ^ w_i[2] ^ w_i[4] ^ w_i[5] ^ w_i[6] ^ w_i[7];
  end

endmodule

// ===== sv/table_spn_block_cipher_top.sv =====
// Top level of the table SPN block cipher: control, lanes, diffusion and ports.
//
//   Channel   Signals                                   Beat
//   in        in_valid_i / in_ready_o / in_data_i       load, encrypt or decrypt command
//   out       out_valid_o / out_ready_i / out_data_o    128-bit result block
//   apb       psel penable pwrite paddr pwdata prdata   round_count register
//
// A load beat writes one table word and leaves the block idle. An encrypt or decrypt runs
// round_count rounds after acceptance, or passes the block through for zero rounds: each of
// the eight lanes reads its table RAM once per cycle, so one round per cycle, and after the
// last read the block moves into the output register once that register is free. The next
// beat is taken once the block has returned to idle.
// The tables are not cleared by reset; round_count resets to twelve.
// A result still held at the output stalls the block in its final cycle.
`include "table_spn_block_cipher_top_macros.svh"

module table_spn_block_cipher_top
  import tspn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_beat_t              in_data_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_beat_t             out_data_o,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [ROUNDS_W-1:0] rounds_q;
  logic [ROUNDS_W-1:0] cnt_q, cnt_d;
  logic                dec_q, dec_d;
  logic                zero_q, zero_d;
  words_t              block_q;
  logic                out_valid_q;
  out_beat_t           out_q;

  logic       in_acc;
  logic       in_crypto;
  logic       in_dec;
  logic       is_idle;
  logic       out_free;
  logic       lane_rd_en;
  logic       lane_dec;
  logic       finish;
  logic       cfg_we;
  words_t     in_words;
  words_t     rd_words;
  words_t     src_words;
  words_t     mix_words;
  words_t     final_words;
  lane_ctrl_t lane_ctrl [WORD_COUNT];

  // Decode the input beat
  assign in_words  = words_t'({in_data_i.block_hi, in_data_i.block_lo});
  assign in_acc    = in_valid_i && in_ready_o;
  assign in_crypto = (in_data_i.cmd == CMD_ENCRYPT) || (in_data_i.cmd == CMD_DECRYPT);
  assign in_dec    = (in_data_i.cmd == CMD_DECRYPT);
  assign is_idle   = (state_q == S_IDLE);
  assign in_ready_o = is_idle;
  assign out_free  = !out_valid_q || out_ready_i;

  // Issue a round read on a crypto beat or while rounds remain
  assign lane_rd_en = (is_idle && in_acc && in_crypto && (rounds_q != '0)) ||
                      ((state_q == S_RUN) && (cnt_q != '0));
  assign lane_dec   = is_idle ? in_dec : dec_q;
  assign finish     = (state_q == S_RUN) && (cnt_q == '0) && out_free;

  // Feed the diffusion from the input block first, then from the lanes
  assign src_words = is_idle ? in_words : rd_words;

  tspn_mix u_mix (
    .w_i (src_words),
    .w_o (mix_words)
  );

  // Replicate the table lanes
  for (genvar g = 0; g < WORD_COUNT; g++) begin : g_lane
    logic             sel_hit;
    logic [ADDR_W-1:0] rd_addr;

    assign sel_hit = in_acc && (in_data_i.table_sel == SEL_W'(g));
    assign lane_ctrl[g] = '{
      rd_en:  lane_rd_en,
      dec:    lane_dec,
      wr_enc: sel_hit && (in_data_i.cmd == CMD_LOAD_ENC),
      wr_dec: sel_hit && (in_data_i.cmd == CMD_LOAD_DEC)
    };
    // Encrypt substitutes first on the opening round; otherwise diffuse first
    assign rd_addr = (is_idle && !in_dec) ? src_words[g] : mix_words[g];

    tspn_lane u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl[g]),
      .rd_addr_i (rd_addr),
      .wr_addr_i (in_data_i.table_addr),
      .wr_data_i (in_data_i.table_data),
      .rd_data_o (rd_words[g])
    );
  end

  // Pick the finished block
  always_comb begin
    if (zero_q) begin
      final_words = block_q;
    end else if (dec_q) begin
      final_words = rd_words;
    end else begin
      final_words = mix_words;
    end
  end

  // Sequence the rounds
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dec_d   = dec_q;
    zero_d  = zero_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_crypto) begin
          state_d = S_RUN;
          dec_d   = in_dec;
          zero_d  = (rounds_q == '0);
          cnt_d   = (rounds_q == '0) ? '0 : rounds_q - ROUNDS_W'(1);
        end
      end
      S_RUN: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - ROUNDS_W'(1);
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      dec_q   <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dec_q   <= dec_d;
      zero_q  <= zero_d;
    end
  end

  // Hold the input block for the zero-round case
  always_ff @(posedge clk_i) begin
    if (in_acc && in_crypto) begin
      block_q <= in_words;
    end
  end

  // Output register: load on finish, drop on a taken beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q.result_lo <= final_words[WORD_COUNT/2-1:0];
      out_q.result_hi <= final_words[WORD_COUNT-1:WORD_COUNT/2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_ROUND_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q <= ROUNDS_RESET;
    end else if (cfg_we) begin
      rounds_q <= pwdata[ROUNDS_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROUND_COUNT: prdata = APB_DATA_W'(rounds_q);
      default:         prdata = '0;
    endcase
  end

  // Checks
  `TSPN_ASSERT(a_crypto_starts_run, (in_acc && in_crypto) |=> (state_q == S_RUN), "crypto beat did not start rounds")
  `TSPN_ASSERT(a_load_stays_idle, (in_acc && !in_crypto) |=> (state_q == S_IDLE), "load beat left idle")
  `TSPN_ASSERT(a_result_after_last_round, $rose(out_valid_q) |-> (($past(state_q) == S_RUN) && ($past(cnt_q) == '0)), "result raised before last round")
  `TSPN_ASSERT_NEVER(a_no_read_during_load, lane_rd_en && (in_acc && !in_crypto), "table read overlaps a load")

endmodule
